// ----- src/usbef_pkg.sv -----
// ----------------------------------------------------------------------------
// usbef_pkg
// Shared types and constants of the USB Ethernet frame receive filter.
// ----------------------------------------------------------------------------
package usbef_pkg;

    // Ethernet header layout
    localparam int HDR_LEN  = 14;
    localparam int DST_END  = 6;
    localparam int SRC_END  = 12;
    localparam int MAC_W    = 48;
    localparam int TYPE_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int PLEN_W   = 11;

    localparam logic [MAC_W-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_MAC = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_ENABLE  = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Queue between classifier and output sequencer
    localparam int QUEUE_DEPTH = 4;

    // Output stream data width: fields padded to whole bytes
    localparam int OUT_FIELDS_W = BYTE_W + 2 * MAC_W + TYPE_W + PLEN_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Results caused by one input item
    typedef struct packed {
        logic                pay_vld;
        logic                end_vld;
        logic [BYTE_W-1:0]   pay_byte;
        logic [MAC_W-1:0]    dst_mac;
        logic [MAC_W-1:0]    src_mac;
        logic [TYPE_W-1:0]   ether_type;
        logic [PLEN_W-1:0]   payload_len;
        logic                overflow;
    } entry_t;

    // One result item on the output stream
    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [MAC_W-1:0]    dst_mac;
        logic [MAC_W-1:0]    src_mac;
        logic [TYPE_W-1:0]   ether_type;
        logic [PLEN_W-1:0]   payload_len;
        logic                overflow;
        logic                last;
    } result_t;

endpackage

// ----- src/usb_ethernet_frame_receive_filter.sv -----
// ----------------------------------------------------------------------------
// usb_ethernet_frame_receive_filter
// Reassembles Ethernet frames from USB bulk OUT bytes and filters by address.
// ----------------------------------------------------------------------------
// One input byte is taken per clock; s_tready drops only when the four-entry
// result queue is full. Each accepted byte is classified in the cycle it is
// taken, and its results reach the m_ side through the queue and a registered
// output stage. A byte that both carries payload and closes the frame gives
// two results, which the output sequencer sends one after the other, so the
// sustained rate is one item per clock while m_tready stays high, except at
// frame ends, where one byte can give two items. Configuration writes are
// always accepted (cfg_ready is tied high) and must be made while idle.
module usb_ethernet_frame_receive_filter
    import usbef_pkg::*;
#(
    parameter int BULK_PACKET_BYTES = 64,
    parameter int MAX_FRAME_BYTES   = 2048
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] has_byte
    input  logic                   s_tlast,   // packet_end
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] payload_byte, [55:8] dst_mac, [103:56] src_mac,
    // [119:104] ether_type, [130:120] payload_len, [131] overflow, rest zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tuser,   // [0] kind
    output logic                   m_tlast,   // last
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [MAC_W-1:0]       cfg_data
);

    logic    q_full, q_head_valid, q_pop, f_push;
    entry_t  f_entry, q_head;
    result_t result;
    logic    in_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    // Classify input bytes
    usbef_front #(
        .BULK_PACKET_BYTES (BULK_PACKET_BYTES),
        .MAX_FRAME_BYTES   (MAX_FRAME_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (in_accept),
        .data_byte   (s_tdata),
        .has_byte    (s_tuser),
        .packet_end  (s_tlast),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (f_push),
        .push_entry  (f_entry)
    );

    // Queue results
    usbef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_entry (f_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    // Sequence results onto the output stream
    usbef_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack output fields
    assign m_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), result.overflow, result.payload_len,
                      result.ether_type, result.src_mac, result.dst_mac,
                      result.payload_byte};
    assign m_tuser = result.kind;
    assign m_tlast = result.last;

    // An end record is always marked last, a payload byte never
    a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_END) == m_tlast)
        else $error("kind and last disagree");

endmodule

// ----- src/usbef_front.sv -----
// ----------------------------------------------------------------------------
// usbef_front
// Header capture, address filter and frame/packet accounting per input byte.
// ----------------------------------------------------------------------------
module usbef_front
    import usbef_pkg::*;
#(
    parameter int BULK_PACKET_BYTES = 64,
    parameter int MAX_FRAME_BYTES   = 2048
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_accept,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   has_byte,
    input  logic                   packet_end,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [MAC_W-1:0]       cfg_data,
    output logic                   push,
    output entry_t                 push_entry
);

    localparam int FC_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int PC_W = $clog2(BULK_PACKET_BYTES + 1);

    logic [MAC_W-1:0]  device_mac_reg;
    logic              rx_enable_reg;

    logic [MAC_W-1:0]  dest_reg, dest_next;
    logic [MAC_W-1:0]  src_reg, src_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic [FC_W-1:0]   fc_reg, fc_next, fc_byte;
    logic [PC_W-1:0]   pc_reg, pc_next, pc_byte;
    logic              match_reg, match_next, match_byte;
    logic              ovf_reg, ovf_next, ovf_byte;
    logic              pay_vld, end_vld;
    logic [MAC_W-1:0]  dest_shift;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_mac_reg <= '0;
            rx_enable_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEVICE_MAC: device_mac_reg <= cfg_data;
                CFG_RX_ENABLE:  rx_enable_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign dest_shift = {dest_reg[MAC_W-BYTE_W-1:0], data_byte};

    // Apply the byte of the item: capture header, count, flag payload
    always_comb
    begin
        dest_next  = dest_reg;
        src_next   = src_reg;
        type_next  = type_reg;
        fc_byte    = fc_reg;
        pc_byte    = pc_reg;
        match_byte = match_reg;
        ovf_byte   = ovf_reg;
        pay_vld    = 1'b0;
        if (item_accept && has_byte)
        begin
            if (pc_reg < PC_W'(BULK_PACKET_BYTES))
                pc_byte = pc_reg + PC_W'(1);
            if (fc_reg < FC_W'(MAX_FRAME_BYTES))
            begin
                if (fc_reg < FC_W'(DST_END))
                begin
                    dest_next = dest_shift;
                    if (fc_reg == FC_W'(DST_END - 1))
                        match_byte = (dest_shift == BCAST_MAC)
                                  || (dest_shift == device_mac_reg);
                end
                else if (fc_reg < FC_W'(SRC_END))
                    src_next = {src_reg[MAC_W-BYTE_W-1:0], data_byte};
                else if (fc_reg < FC_W'(HDR_LEN))
                    type_next = {type_reg[TYPE_W-BYTE_W-1:0], data_byte};
                else if (match_reg && rx_enable_reg)
                    pay_vld = 1'b1;
                fc_byte = fc_reg + FC_W'(1);
            end
            else
                ovf_byte = 1'b1;
        end
    end

    // Apply the packet end: close the frame on a short packet
    always_comb
    begin
        fc_next    = fc_byte;
        pc_next    = pc_byte;
        match_next = match_byte;
        ovf_next   = ovf_byte;
        end_vld    = 1'b0;
        if (item_accept && packet_end)
        begin
            if (pc_byte < PC_W'(BULK_PACKET_BYTES))
            begin
                end_vld    = (fc_byte >= FC_W'(HDR_LEN)) && match_byte && rx_enable_reg;
                fc_next    = '0;
                pc_next    = '0;
                match_next = 1'b0;
                ovf_next   = 1'b0;
            end
            else
                pc_next = '0;
        end
    end

    // Build the queue entry
    always_comb
    begin
        push_entry.pay_vld     = pay_vld;
        push_entry.end_vld     = end_vld;
        push_entry.pay_byte    = data_byte;
        push_entry.dst_mac     = dest_next;
        push_entry.src_mac     = src_next;
        push_entry.ether_type  = type_next;
        push_entry.payload_len = PLEN_W'(fc_byte - FC_W'(HDR_LEN));
        push_entry.overflow    = ovf_byte;
    end

    assign push = pay_vld || end_vld;

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg  <= '0;
            src_reg   <= '0;
            type_reg  <= '0;
            fc_reg    <= '0;
            pc_reg    <= '0;
            match_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            dest_reg  <= dest_next;
            src_reg   <= src_next;
            type_reg  <= type_next;
            fc_reg    <= fc_next;
            pc_reg    <= pc_next;
            match_reg <= match_next;
            ovf_reg   <= ovf_next;
        end
    end

    // A byte kept in a frame never pushes the count past capacity
    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FC_W'(MAX_FRAME_BYTES))
        else $error("frame count beyond capacity");

    // An end record only leaves with a full header behind it
    a_end_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.end_vld |-> fc_byte >= FC_W'(HDR_LEN))
        else $error("end record for a short frame");

    // Frame state is cleared after a frame closes
    a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.end_vld |=> fc_reg == '0 && !match_reg && !ovf_reg)
        else $error("frame state not cleared after end record");

endmodule

// ----- src/usbef_queue.sv -----
// ----------------------------------------------------------------------------
// usbef_queue
// Short FIFO of per-item result entries between classifier and sequencer.
// ----------------------------------------------------------------------------
module usbef_queue
    import usbef_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // Never push into a full queue
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    // Never pop an empty queue
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    // Every stored entry carries at least one result
    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> head_entry.pay_vld || head_entry.end_vld)
        else $error("queue entry without result");

endmodule

// ----- src/usbef_back.sv -----
// ----------------------------------------------------------------------------
// usbef_back
// Expands queue entries into payload and end records behind an output register.
// ----------------------------------------------------------------------------
module usbef_back
    import usbef_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  entry_t  head_entry,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    pay_done_reg, pay_done_next;
    logic    load, sel_end;

    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign sel_end = !head_entry.pay_vld || pay_done_reg;

    // Select the next result of the head entry
    always_comb
    begin
        out_next       = out_reg;
        pay_done_next  = pay_done_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (sel_end)
            begin
                out_next.kind         = KIND_END;
                out_next.payload_byte = '0;
                out_next.dst_mac      = head_entry.dst_mac;
                out_next.src_mac      = head_entry.src_mac;
                out_next.ether_type   = head_entry.ether_type;
                out_next.payload_len  = head_entry.payload_len;
                out_next.overflow     = head_entry.overflow;
                out_next.last         = 1'b1;
                pop                   = 1'b1;
                pay_done_next         = 1'b0;
            end
            else
            begin
                out_next              = '0;
                out_next.kind         = KIND_PAYLOAD;
                out_next.payload_byte = head_entry.pay_byte;
                pop                   = !head_entry.end_vld;
                pay_done_next         = head_entry.end_vld;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pay_done_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pay_done_reg  <= pay_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // The payload half of an entry is followed by its end record
    a_split_pair: assert property (@(posedge clk) disable iff (!rst_n)
        pay_done_reg |-> head_valid && head_entry.end_vld)
        else $error("pending end record lost");

endmodule

// ----- bench/usb_ethernet_frame_receive_filter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usb_ethernet_frame_receive_filter_tb
// Self-checking bench for the USB Ethernet frame receive filter. A queue of
// USB bulk OUT bytes is fed through the input stream by a clocked driver.
// Every accepted byte also runs through a frame reassembly and address filter
// predictor, and the results it expects are compared with the output stream.
// The run goes through directed corner frames, random well-formed and broken
// frames under several address and enable settings, and random stalls on
// both streams.
// ----------------------------------------------------------------------------
module usb_ethernet_frame_receive_filter_tb
    import usbef_pkg::*;
();

    localparam int BULK_BYTES    = 64;
    localparam int FRAME_CAP     = 2048;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_AFTER    = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    // Field positions in the output tdata
    localparam int PAY_LSB  = 0;
    localparam int DST_LSB  = PAY_LSB + BYTE_W;
    localparam int SRC_LSB  = DST_LSB + MAC_W;
    localparam int TYPE_LSB = SRC_LSB + MAC_W;
    localparam int PLEN_LSB = TYPE_LSB + TYPE_W;
    localparam int OVF_BIT  = PLEN_LSB + PLEN_W;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              pkt_end;
    } usb_byte_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [MAC_W-1:0]       cfg_data  = '0;

    // Stimulus and expectations
    usb_byte_t usb_bytes_to_send[$];
    result_t   outbound_results[$];

    // Predictor copy of the registers and the frame state
    logic [MAC_W-1:0]  mac_setting    = '0;
    logic              rx_on          = 1'b0;
    logic [MAC_W-1:0]  hdr_dst        = '0;
    logic [MAC_W-1:0]  hdr_src        = '0;
    logic [TYPE_W-1:0] hdr_type       = '0;
    int                frame_bytes    = 0;
    int                pkt_bytes      = 0;
    logic              dst_accepted   = 1'b0;
    logic              frame_overflow = 1'b0;

    // Bookkeeping
    int   cycle_count     = 0;
    int   bytes_taken     = 0;
    int   planned_items   = 0;
    int   fault_count     = 0;
    int   payloads_seen   = 0;
    int   records_seen    = 0;
    int   overflow_seen   = 0;
    int   hold_left       = 0;
    logic hold_done       = 1'b0;
    logic steady;

    assign steady = (cycle_count >= 700) && (cycle_count < 1000);

    usb_ethernet_frame_receive_filter #(
        .BULK_PACKET_BYTES (BULK_BYTES),
        .MAX_FRAME_BYTES   (FRAME_CAP)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Track cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, outbound_results.size());
            $display("usb_ethernet_frame_receive_filter regression: fail");
            $finish;
        end
    end

    // Advance the frame state by one USB byte and queue the results it gives
    function automatic void reassemble_and_filter(input logic [BYTE_W-1:0] data,
                                                  input logic has_byte,
                                                  input logic pkt_end);
        result_t r;
        if (has_byte)
        begin
            if (pkt_bytes < BULK_BYTES)
                pkt_bytes++;
            if (frame_bytes < FRAME_CAP)
            begin
                if (frame_bytes < DST_END)
                begin
                    hdr_dst = {hdr_dst[MAC_W-BYTE_W-1:0], data};
                    if (frame_bytes == DST_END - 1)
                        dst_accepted = (hdr_dst == BCAST_MAC) || (hdr_dst == mac_setting);
                end
                else if (frame_bytes < SRC_END)
                    hdr_src = {hdr_src[MAC_W-BYTE_W-1:0], data};
                else if (frame_bytes < HDR_LEN)
                    hdr_type = {hdr_type[TYPE_W-BYTE_W-1:0], data};
                else if (dst_accepted && rx_on)
                begin
                    r = '0;
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = data;
                    outbound_results.push_back(r);
                end
                frame_bytes++;
            end
            else
                frame_overflow = 1'b1;
        end
        if (pkt_end)
        begin
            // a short packet closes the frame, a full one only restarts the count
            if (pkt_bytes < BULK_BYTES)
            begin
                if (frame_bytes >= HDR_LEN && dst_accepted && rx_on)
                begin
                    r = '0;
                    r.kind        = KIND_END;
                    r.dst_mac     = hdr_dst;
                    r.src_mac     = hdr_src;
                    r.ether_type  = hdr_type;
                    r.payload_len = PLEN_W'(frame_bytes - HDR_LEN);
                    r.overflow    = frame_overflow;
                    r.last        = 1'b1;
                    outbound_results.push_back(r);
                end
                frame_bytes    = 0;
                pkt_bytes      = 0;
                dst_accepted   = 1'b0;
                frame_overflow = 1'b0;
            end
            else
                pkt_bytes = 0;
        end
    endfunction

    // Drive USB bytes from the pending queue
    always @(posedge clk or negedge rst_n)
    begin : drive_usb_bytes
        usb_byte_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reassemble_and_filter(s_tdata, s_tuser, s_tlast);
                bytes_taken <= bytes_taken + 1;
            end
            // offer the next request once the current one is gone
            if (!s_tvalid || s_tready)
            begin
                if (usb_bytes_to_send.size() != 0 &&
                    (steady || $urandom_range(99, 0) >= 30))
                begin
                    nxt = usb_bytes_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.has_byte;
                    s_tlast  <= nxt.pkt_end;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    function automatic void note_fault(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("mismatch on %s at cycle %0d: expected %h, got %h",
                     what, cycle_count, want, got);
    endfunction

    // Check each accepted result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : check_results
        result_t want;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (outbound_results.size() == 0)
                    note_fault("result with none expected (kind)", '0, 64'(m_tuser));
                else
                begin
                    want = outbound_results.pop_front();
                    if (want.kind == KIND_END)
                    begin
                        records_seen++;
                        if (want.overflow)
                            overflow_seen++;
                    end
                    else
                        payloads_seen++;
                    if (m_tuser !== want.kind)
                        note_fault("kind", 64'(want.kind), 64'(m_tuser));
                    if (m_tdata[PAY_LSB +: BYTE_W] !== want.payload_byte)
                        note_fault("payload_byte", 64'(want.payload_byte),
                                   64'(m_tdata[PAY_LSB +: BYTE_W]));
                    if (m_tdata[DST_LSB +: MAC_W] !== want.dst_mac)
                        note_fault("dst_mac", 64'(want.dst_mac), 64'(m_tdata[DST_LSB +: MAC_W]));
                    if (m_tdata[SRC_LSB +: MAC_W] !== want.src_mac)
                        note_fault("src_mac", 64'(want.src_mac), 64'(m_tdata[SRC_LSB +: MAC_W]));
                    if (m_tdata[TYPE_LSB +: TYPE_W] !== want.ether_type)
                        note_fault("ether_type", 64'(want.ether_type),
                                   64'(m_tdata[TYPE_LSB +: TYPE_W]));
                    if (m_tdata[PLEN_LSB +: PLEN_W] !== want.payload_len)
                        note_fault("payload_len", 64'(want.payload_len),
                                   64'(m_tdata[PLEN_LSB +: PLEN_W]));
                    if (m_tdata[OVF_BIT] !== want.overflow)
                        note_fault("overflow", 64'(want.overflow), 64'(m_tdata[OVF_BIT]));
                    if (m_tlast !== want.last)
                        note_fault("last", 64'(want.last), 64'(m_tlast));
                end
            end
            // hold off once for a long stretch so the block backs up
            if (!hold_done && bytes_taken >= HOLD_AFTER)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                m_tready  <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(99, 0) >= 30);
        end
    end

    function automatic logic [BYTE_W-1:0] random_byte();
        int pick;
        pick = $urandom_range(7, 0);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        return BYTE_W'($urandom);
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic void push_item(input logic [BYTE_W-1:0] data, input logic has_byte,
                                      input logic pkt_end);
        usb_byte_t item;
        item.data     = data;
        item.has_byte = has_byte;
        item.pkt_end  = pkt_end;
        usb_bytes_to_send.push_back(item);
        planned_items++;
    endfunction

    // Queue one frame of total bytes, split into bulk packets when closed
    task automatic queue_frame(input logic [MAC_W-1:0] dst, input int total,
                               input bit noise, input bit close);
        logic [BYTE_W-1:0] body[$];
        logic [MAC_W-1:0]  src;
        logic [TYPE_W-1:0] ethtype;
        int                idx;
        int                chunk;
        bit                full;
        src     = random_mac();
        ethtype = TYPE_W'($urandom);
        for (int i = MAC_W / BYTE_W - 1; i >= 0; i--)
            body.push_back(dst[i*BYTE_W +: BYTE_W]);
        for (int i = MAC_W / BYTE_W - 1; i >= 0; i--)
            body.push_back(src[i*BYTE_W +: BYTE_W]);
        body.push_back(ethtype[TYPE_W-1 -: BYTE_W]);
        body.push_back(ethtype[BYTE_W-1:0]);
        while (body.size() < total)
            body.push_back(random_byte());
        while (body.size() > total)
            void'(body.pop_back());
        if (!close)
        begin
            foreach (body[i])
                push_item(body[i], 1'b1, 1'b0);
            return;
        end
        if (total == 0)
        begin
            push_item(random_byte(), 1'b0, 1'b1);
            return;
        end
        idx = 0;
        while (idx < total)
        begin
            // now and then an overlong packet, which still counts as full
            if (noise && total - idx > BULK_BYTES + 20 && $urandom_range(9, 0) == 0)
                chunk = BULK_BYTES + $urandom_range(20, 1);
            else if (total - idx >= BULK_BYTES)
                chunk = BULK_BYTES;
            else
                chunk = total - idx;
            full = (chunk >= BULK_BYTES);
            for (int k = 0; k < chunk; k++)
            begin
                if (noise && $urandom_range(24, 0) == 0)
                    push_item(random_byte(), 1'b0, 1'b0);
                push_item(body[idx + k], 1'b1, k == chunk - 1);
            end
            idx += chunk;
            // a frame ending on a full packet needs an empty one to close it
            if (idx == total && full)
                push_item(random_byte(), 1'b0, 1'b1);
        end
    endtask

    function automatic logic [MAC_W-1:0] pick_dst();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 40)
            return BCAST_MAC;
        else if (pick < 75)
            return mac_setting;
        else if (pick < 85)
            return mac_setting ^ (48'd1 << $urandom_range(MAC_W - 1, 0));
        return random_mac();
    endfunction

    // Mostly short well-formed frames, some runts and a few long ones
    task automatic queue_random_frames(input int target);
        int start;
        int pick;
        int total;
        start = planned_items;
        while (planned_items - start < target)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 8)
                total = $urandom_range(HDR_LEN - 1, 0);
            else if (pick < 80)
                total = HDR_LEN + $urandom_range(40, 0);
            else if (pick < 96)
                total = HDR_LEN + $urandom_range(140, 41);
            else
                total = HDR_LEN + $urandom_range(200, 141);
            queue_frame(pick_dst(), total, 1'b1, 1'b1);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [MAC_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_DEVICE_MAC)
            mac_setting = value;
        else
            rx_on = value[0];
        cfg_valid <= 1'b0;
    endtask

    task automatic set_phase(input logic [MAC_W-1:0] mac, input logic enable);
        logic [MAC_W-1:0] en_word;
        en_word    = random_mac();
        en_word[0] = enable;
        write_reg(CFG_DEVICE_MAC, mac);
        write_reg(CFG_RX_ENABLE, en_word);
        @(negedge clk);
    endtask

    // Hold the sender until every expected result is out, then let it settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (usb_bytes_to_send.size() != 0 || s_tvalid || outbound_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_phase(random_mac(), 1'b1);

        // runt frame, ignored item and a lone empty packet: all silent
        queue_frame(BCAST_MAC, 3, 1'b0, 1'b1);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);

        // frame to the device address, with enable and address changed mid-frame
        queue_frame(mac_setting, HDR_LEN + 2, 1'b0, 1'b0);
        wait_drained();
        set_phase(random_mac(), 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        wait_drained();
        set_phase(mac_setting, 1'b1);
        push_item(8'h3C, 1'b0, 1'b1);
        wait_drained();

        // random frames under several settings
        set_phase(random_mac(), 1'b1);
        queue_random_frames(260);
        wait_drained();
        set_phase(BCAST_MAC, 1'b1);
        queue_random_frames(150);
        wait_drained();
        set_phase('0, 1'b1);
        queue_random_frames(120);
        wait_drained();
        set_phase(random_mac(), 1'b0);
        queue_random_frames(100);
        wait_drained();

        // a last batch back on a fresh device address
        set_phase(random_mac(), 1'b1);
        queue_random_frames(60);
        wait_drained();

        $display("Sent %0d USB items; checked %0d payload bytes and %0d frame records",
                 bytes_taken, payloads_seen, records_seen);
        $display("(%0d with overflow) across address, broadcast and enable settings",
                 overflow_seen);
        if (fault_count == 0 && outbound_results.size() == 0)
            $display("usb_ethernet_frame_receive_filter regression: pass");
        else
            $display("usb_ethernet_frame_receive_filter regression: fail");
        $finish;
    end

endmodule
